// ===== sv/buddy_block_allocator_unit_assert.svh =====
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define BBA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bba assertion failed");
// Next-cycle implication, checked while out of reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bba assertion failed");
`else
`define BBA_ASSERT_IMP(lbl, ante, cons)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/bba_pkg.sv =====
// Shared types and codes of the buddy block allocator.
package bba_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_SCAN,
		ST_MARK,
		ST_SPLIT,
		ST_MUL,
		ST_ADD,
		ST_FRD,
		ST_FCHK,
		ST_DONE
	} bba_state_t;

	localparam logic       MODE_ALLOC = 1'b0;
	localparam logic       MODE_FREE  = 1'b1;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NOFREE = 2'd1;
	localparam logic [1:0] STAT_BADIDX = 2'd2;

	localparam logic       CFG_MIN_BLOCK = 1'b0;
	localparam logic       CFG_BASE_ADDR = 1'b1;

endpackage

// ===== sv/bba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 255
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/buddy_block_allocator_unit.sv =====
// Buddy block allocator: request sequencer, free bitmap RAM and result register.
//
// Requests enter on the s_ stream, one beat per request; tuser selects allocate or
// free. Each request gives exactly one result beat on the m_ stream, with the
// status in tuser. Configuration writes go over the cfg channel, which is always
// ready, and are meant to be made while no request is in flight.
// After reset the block sweeps the free bitmap RAM once, one node a cycle, over
// every node of the tree; s_tready stays low meanwhile and the bitmap then holds
// only the root as free.
// One request at a time: s_tready is high only while the sequencer is idle.
// An allocate first finds the level, then makes one RAM read per scanned node
// (a lowest-free scan from the wanted level toward the root, at most
// 2^NUM_LEVELS - 1 nodes), one write to take the block and one per split level,
// then forms the address with a multiply and an add. A free reads and checks
// the buddy per merged level. The single RAM port pair makes these steps serial.
// The result register parts the two sides: a new request is taken while a
// result still waits, and a finished request holds in its last step until the
// receiver has taken the previous result.
`include "buddy_block_allocator_unit_assert.svh"

module buddy_block_allocator_unit
	import bba_pkg::*;
#(
	parameter int NUM_LEVELS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // alloc_size[23:0], free_index[31:24]
	input  logic [0:0]  s_tuser,    // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // block_index[7:0], block_level[10:8], address[42:11], zero
	output logic [1:0]  m_tuser,    // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NODES = (1 << NUM_LEVELS) - 1;
	localparam int IW    = NUM_LEVELS;
	localparam int LW    = $clog2(NUM_LEVELS);
	localparam int CW    = 13 + NUM_LEVELS;
	localparam int PW    = IW + 13;

	function automatic int lvl_first(input int lvl);
		return (1 << lvl) - 1;
	endfunction

	function automatic int lvl_last(input int lvl);
		return (2 << lvl) - 2;
	endfunction

	bba_state_t state_q, state_d;

	logic [12:0]    min_block_q;
	logic [31:0]    base_addr_q;
	logic [IW-1:0]  clr_q;
	logic           m_tvalid_q;

	logic [23:0]    size_q;
	logic [CW-1:0]  cur_q;
	logic [LW-1:0]  want_q;
	logic [IW-1:0]  idx_q;
	logic [LW-1:0]  lvl_q;
	logic [IW-1:0]  scan_q;
	logic [LW-1:0]  scan_lvl_q;
	logic           issued_all_q;
	logic           chk_vld_q;
	logic [IW-1:0]  chk_idx_q;
	logic [LW-1:0]  chk_lvl_q;
	logic [PW-1:0]  prod_q;
	logic [1:0]     res_status_q;
	logic [7:0]     res_idx_q;
	logic [2:0]     res_lvl_q;
	logic [31:0]    res_addr_q;
	logic [1:0]     out_status_q;
	logic [7:0]     out_idx_q;
	logic [2:0]     out_lvl_q;
	logic [31:0]    out_addr_q;

	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	logic [0:0]     ram_wdata;
	logic           ram_re;
	logic [IW-1:0]  ram_raddr;
	logic [0:0]     ram_rdata;

	logic [12:0]    leaf;
	logic           in_beat;
	logic           out_free;
	logic           cur_lt_size;
	logic           scan_at_last;
	logic           found;
	logic [IW-1:0]  buddy;
	logic [IW-1:0]  parent;
	logic [IW-1:0]  split_right;
	logic [IW+7:0]  req_ext;
	logic           req_bad;
	logic [IW-1:0]  req_p1;
	logic [LW-1:0]  req_lvl;
	logic [IW+7:0]  idx_wide;
	logic [LW+2:0]  want_wide;
	logic [LW+2:0]  req_lvl_wide;
	logic [IW-1:0]  offset;
	logic [IW-1:0]  offset_sh;

	assign leaf         = (min_block_q == 13'd0) ? 13'd1 : min_block_q;
	assign in_beat      = s_tvalid && s_tready;
	assign out_free     = !m_tvalid_q || m_tready;
	assign cur_lt_size  = (CW + 24)'(cur_q) < (CW + 24)'(size_q);
	assign scan_at_last = scan_q == IW'(lvl_last(int'(scan_lvl_q)));
	assign found        = chk_vld_q && ram_rdata[0];
	assign buddy        = idx_q[0] ? idx_q + IW'(1) : idx_q - IW'(1);
	assign parent       = (idx_q - IW'(1)) >> 1;
	assign split_right  = {idx_q[IW-2:0], 1'b0} + IW'(2);
	assign req_ext      = {{IW{1'b0}}, s_tdata[31:24]};
	assign req_bad      = req_ext >= (IW + 8)'(NODES);
	assign req_p1       = req_ext[IW-1:0] + IW'(1);
	assign idx_wide     = {8'd0, idx_q};
	assign want_wide    = {3'd0, want_q};
	assign req_lvl_wide = {3'd0, req_lvl};
	assign offset       = idx_q - IW'(lvl_first(int'(want_q)));
	assign offset_sh    = offset << (LW'(NUM_LEVELS - 1) - want_q);

	// Tree level of a node: position of the top set bit of index + 1.
	always_comb begin
		req_lvl = '0;
		for (int i = 0; i < IW; i++) begin
			if (req_p1[i]) begin
				req_lvl = LW'(i);
			end
		end
	end

	bba_ram #(
		.WIDTH(1),
		.DEPTH(NODES)
	) u_free_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IW'(NODES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_beat) begin
					if (s_tuser[0] == MODE_ALLOC) begin
						state_d = ST_CALC;
					end else if (req_bad) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_FRD;
					end
				end
			end
			ST_CALC: begin
				if (!cur_lt_size) begin
					state_d = ST_SCAN;
				end else if (want_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (found) begin
					state_d = ST_MARK;
				end else if (issued_all_q && !chk_vld_q) begin
					state_d = ST_DONE;
				end
			end
			ST_MARK: begin
				state_d = (lvl_q == want_q) ? ST_MUL : ST_SPLIT;
			end
			ST_SPLIT: begin
				if (lvl_q + LW'(1) == want_q) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_ADD;
			ST_ADD:  state_d = ST_DONE;
			ST_FRD: begin
				state_d = (idx_q == '0) ? ST_DONE : ST_FCHK;
			end
			ST_FCHK: begin
				state_d = ram_rdata[0] ? ST_FRD : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = scan_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == '0);
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_SCAN: begin
				ram_re = !issued_all_q;
			end
			ST_MARK: begin
				ram_we = 1'b1;
			end
			ST_SPLIT: begin
				ram_we    = 1'b1;
				ram_waddr = split_right;
				ram_wdata = 1'b1;
			end
			ST_FRD: begin
				// The climbing node is cleared now (set if it is the root) and set again where the merge stops.
				ram_we    = 1'b1;
				ram_wdata = (idx_q == '0);
				ram_re    = (idx_q != '0);
				ram_raddr = buddy;
			end
			ST_FCHK: begin
				ram_we    = 1'b1;
				ram_waddr = ram_rdata[0] ? buddy : idx_q;
				ram_wdata = !ram_rdata[0];
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_status_q;
	assign m_tdata   = {5'd0, out_addr_q, out_lvl_q, out_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			m_tvalid_q  <= 1'b0;
			min_block_q <= 13'd16;
			base_addr_q <= 32'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IW'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MIN_BLOCK) begin
					min_block_q <= cfg_data[12:0];
				end else if (cfg_index == CFG_BASE_ADDR) begin
					base_addr_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				size_q    <= s_tdata[23:0];
				cur_q     <= CW'(leaf);
				want_q    <= LW'(NUM_LEVELS - 1);
				idx_q     <= req_ext[IW-1:0];
				res_addr_q <= 32'd0;
				if (s_tuser[0] == MODE_FREE && req_bad) begin
					res_status_q <= STAT_BADIDX;
					res_idx_q    <= 8'd0;
					res_lvl_q    <= 3'd0;
				end else begin
					res_status_q <= STAT_OK;
					res_idx_q    <= s_tdata[31:24];
					res_lvl_q    <= req_lvl_wide[2:0];
				end
			end
			ST_CALC: begin
				if (!cur_lt_size) begin
					scan_q       <= IW'(lvl_first(int'(want_q)));
					scan_lvl_q   <= want_q;
					issued_all_q <= 1'b0;
					chk_vld_q    <= 1'b0;
				end else if (want_q == '0) begin
					res_status_q <= STAT_NOFREE;
					res_idx_q    <= 8'd0;
					res_lvl_q    <= 3'd0;
				end else begin
					cur_q  <= cur_q << 1;
					want_q <= want_q - LW'(1);
				end
			end
			ST_SCAN: begin
				if (found) begin
					idx_q <= chk_idx_q;
					lvl_q <= chk_lvl_q;
				end else if (!issued_all_q) begin
					chk_vld_q <= 1'b1;
					chk_idx_q <= scan_q;
					chk_lvl_q <= scan_lvl_q;
					if (!scan_at_last) begin
						scan_q <= scan_q + IW'(1);
					end else if (scan_lvl_q == '0) begin
						issued_all_q <= 1'b1;
					end else begin
						scan_lvl_q <= scan_lvl_q - LW'(1);
						scan_q     <= IW'(lvl_first(int'(scan_lvl_q) - 1));
					end
				end else begin
					chk_vld_q <= 1'b0;
					if (!chk_vld_q) begin
						res_status_q <= STAT_NOFREE;
						res_idx_q    <= 8'd0;
						res_lvl_q    <= 3'd0;
					end
				end
			end
			ST_SPLIT: begin
				idx_q <= {idx_q[IW-2:0], 1'b1};
				lvl_q <= lvl_q + LW'(1);
			end
			ST_MUL: begin
				prod_q <= PW'(offset_sh) * PW'(leaf);
			end
			ST_ADD: begin
				res_addr_q <= base_addr_q + 32'(prod_q);
				res_idx_q  <= idx_wide[7:0];
				res_lvl_q  <= want_wide[2:0];
			end
			ST_FCHK: begin
				if (ram_rdata[0]) begin
					idx_q <= parent;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_idx_q    <= res_idx_q;
					out_lvl_q    <= res_lvl_q;
					out_addr_q   <= res_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

	`BBA_ASSERT_NEXT(a_busy_after_request, in_beat, !s_tready)
	`BBA_ASSERT_IMP(a_write_in_tree, ram_we, int'(ram_waddr) < NODES)
	`BBA_ASSERT_IMP(a_result_from_done, $rose(m_tvalid), $past(state_q == ST_DONE))

endmodule
